// ----- sv/pzbc_pkg.sv -----
// pzbc_pkg: shared types, constants and bar-group functions for the POSTNET codec.
// Used by pzbc_enc, pzbc_dec and postnet_zip_barcode_codec_unit; depends on nothing.

package pzbc_pkg;

	localparam int ZIP_W  = 17;
	localparam int BARS_W = 27;
	localparam int GRP_W  = 5;
	localparam int DIGITS = 5;
	localparam int PROD_W = 35;

	// Operation codes carried on func.
	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	// Reciprocals ceil(2^s / 10^k), exact for every 17-bit value:
	// floor(zip / 10^k) == (zip * RECIP) >> s.
	localparam logic [17:0] RECIP_1E1 = 18'd209716; // s = 21
	localparam logic [17:0] RECIP_1E2 = 18'd167773; // s = 24
	localparam logic [17:0] RECIP_1E3 = 18'd134218; // s = 27
	localparam logic [17:0] RECIP_1E4 = 18'd214749; // s = 31

	localparam logic [3:0] DIGIT_MAX = 4'd9;

	// Decimal place of each group, first group first.
	localparam logic [ZIP_W-1:0] PLACE [DIGITS] = '{
		17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
	};

	typedef struct packed {
		logic [ZIP_W-1:0]  zip;
		logic [BARS_W-1:0] bars;
		logic              error;
	} res_t;

	// Two-of-five pattern for a decimal digit; codes above nine map to no bars.
	function automatic logic [GRP_W-1:0] digit_group(input logic [3:0] d);
		logic [GRP_W-1:0] g;
		begin
			unique case (d)
				4'd0: g = 5'b11000;
				4'd1: g = 5'b00011;
				4'd2: g = 5'b00101;
				4'd3: g = 5'b00110;
				4'd4: g = 5'b01001;
				4'd5: g = 5'b01010;
				4'd6: g = 5'b01100;
				4'd7: g = 5'b10001;
				4'd8: g = 5'b10010;
				4'd9: g = 5'b10100;
				default: g = '0;
			endcase
			return g;
		end
	endfunction

	// Weighted group total 7,4,2,1,0; a total of eleven stands for zero.
	function automatic logic [3:0] group_digit(input logic [GRP_W-1:0] g);
		logic [3:0] t;
		begin
			t = (g[4] ? 4'd7 : 4'd0) + (g[3] ? 4'd4 : 4'd0)
				+ (g[2] ? 4'd2 : 4'd0) + (g[1] ? 4'd1 : 4'd0);
			if (t == 4'd11) begin
				t = 4'd0;
			end
			return t;
		end
	endfunction

endpackage

// ----- sv/postnet_zip_barcode_codec_unit.sv -----
// postnet_zip_barcode_codec_unit: POSTNET 5-digit ZIP encoder/decoder, top level.
// Path: input register, then the codec logic, then the result register that drives the outputs.
// Throughput: one request per cycle while out_ready stays high; a stalled result holds the flow.
// A stalled result still lets one more request enter the input register.
// Reset (arst_n low, asynchronous): both stage valid flags clear; payload is not reset.
// Depends on pzbc_pkg, pzbc_enc, pzbc_dec.

module postnet_zip_barcode_codec_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [pzbc_pkg::ZIP_W-1:0]   zip_in,
	input  logic [pzbc_pkg::BARS_W-1:0]  bars_in,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pzbc_pkg::ZIP_W-1:0]   zip_out,
	output logic [pzbc_pkg::BARS_W-1:0]  bars_out,
	output logic                         error
);

	// Stage 1: captured request.
	logic                        valid_s1;
	logic                        func_s1;
	logic [pzbc_pkg::ZIP_W-1:0]  zip_s1;
	logic [pzbc_pkg::BARS_W-1:0] bars_s1;

	// Stage 2: finished result.
	logic           valid_s2;
	pzbc_pkg::res_t res_s2;

	pzbc_pkg::res_t enc_res, dec_res, sel_res;
	logic           adv_s2;
	logic           take_in;

	// Advance into the result register when it is empty or being drained.
	assign adv_s2   = ~valid_s2 | out_ready;
	// Take a new request when the input register is empty or moving on.
	assign in_ready = ~valid_s1 | adv_s2;
	assign take_in  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1 <= func;
			zip_s1  <= zip_in;
			bars_s1 <= bars_in;
		end
	end

	pzbc_enc u_enc (
		.zip (zip_s1),
		.res (enc_res)
	);

	pzbc_dec u_dec (
		.bars (bars_s1),
		.res  (dec_res)
	);

	// Pick the result of the requested operation.
	always_comb begin
		unique case (func_s1)
			pzbc_pkg::FUNC_ENCODE: sel_res = enc_res;
			pzbc_pkg::FUNC_DECODE: sel_res = dec_res;
			default:               sel_res = enc_res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the result while the consumer stalls.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= sel_res;
		end
	end

	assign out_valid = valid_s2;
	assign zip_out   = res_s2.zip;
	assign bars_out  = res_s2.bars;
	assign error     = res_s2.error;

	// An encoded result never carries a ZIP value, and a decoded one never carries bars.
	a_zip_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (zip_out != '0) |-> (bars_out == '0) && !error)
		else $error("decoded ZIP and bar code both nonzero");

	// Every encoded code is framed by full start and stop bars.
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bars_out != '0) |-> bars_out[pzbc_pkg::BARS_W-1] && bars_out[0])
		else $error("encoded code missing frame bars");

	// Requests are refused only when both stages are full.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("request refused with room in the pipeline");

	// A stage-1 request moves into the result register on the next edge unless stalled.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("request lost between stages");

endmodule

// ----- sv/pzbc_enc.sv -----
// pzbc_enc: ZIP value to 27-bit framed POSTNET code, purely combinational.
// Depends on pzbc_pkg.

module pzbc_enc (
	input  logic [pzbc_pkg::ZIP_W-1:0] zip,
	output pzbc_pkg::res_t             res
);

	logic [pzbc_pkg::PROD_W-1:0] p1, p2, p3, p4;
	logic [13:0] q1;
	logic [10:0] q2;
	logic [7:0]  q3;
	logic [3:0]  q4;
	logic [16:0] t0;
	logic [13:0] t1;
	logic [10:0] t2;
	logic [7:0]  t3;

	// Quotients by 10, 100, 1000, 10000, all taken from zip in parallel.
	assign p1 = pzbc_pkg::PROD_W'(zip) * pzbc_pkg::PROD_W'(pzbc_pkg::RECIP_1E1);
	assign p2 = pzbc_pkg::PROD_W'(zip) * pzbc_pkg::PROD_W'(pzbc_pkg::RECIP_1E2);
	assign p3 = pzbc_pkg::PROD_W'(zip) * pzbc_pkg::PROD_W'(pzbc_pkg::RECIP_1E3);
	assign p4 = pzbc_pkg::PROD_W'(zip) * pzbc_pkg::PROD_W'(pzbc_pkg::RECIP_1E4);

	assign q1 = p1[34:21];
	assign q2 = p2[34:24];
	assign q3 = p3[34:27];
	assign q4 = p4[34:31];

	// Digit k = q_k - 10 * q_(k+1); the low four bits hold the exact digit.
	assign t0 = zip - ({3'b0, q1} << 3) - ({3'b0, q1} << 1);
	assign t1 = q1 - ({3'b0, q2} << 3) - ({3'b0, q2} << 1);
	assign t2 = q2 - ({3'b0, q3} << 3) - ({3'b0, q3} << 1);
	assign t3 = q3 - ({4'b0, q4} << 3) - ({4'b0, q4} << 1);

	always_comb begin
		res.zip   = '0;
		res.error = (q4 > pzbc_pkg::DIGIT_MAX);
		res.bars  = {1'b1,
			pzbc_pkg::digit_group(q4),
			pzbc_pkg::digit_group(t3[3:0]),
			pzbc_pkg::digit_group(t2[3:0]),
			pzbc_pkg::digit_group(t1[3:0]),
			pzbc_pkg::digit_group(t0[3:0]),
			1'b1};
	end

endmodule

// ----- sv/pzbc_dec.sv -----
// pzbc_dec: 27-bit POSTNET code to ZIP value with frame and group checks.
// Combinational; depends on pzbc_pkg.

module pzbc_dec (
	input  logic [pzbc_pkg::BARS_W-1:0] bars,
	output pzbc_pkg::res_t              res
);

	logic [pzbc_pkg::GRP_W-1:0] grp   [pzbc_pkg::DIGITS];
	logic [pzbc_pkg::DIGITS-1:0] grp_ok;
	logic [pzbc_pkg::ZIP_W-1:0] term  [pzbc_pkg::DIGITS];
	logic [pzbc_pkg::ZIP_W-1:0] value;
	logic frame_ok;

	assign frame_ok = bars[pzbc_pkg::BARS_W-1] & bars[0];

	always_comb begin
		for (int i = 0; i < pzbc_pkg::DIGITS; i++) begin
			grp[i]    = bars[(pzbc_pkg::BARS_W - 2 - pzbc_pkg::GRP_W * i) -: pzbc_pkg::GRP_W];
			grp_ok[i] = ($countones(grp[i]) == 2);
			term[i]   = pzbc_pkg::ZIP_W'(pzbc_pkg::group_digit(grp[i])) * pzbc_pkg::PLACE[i];
		end
		value = term[0] + term[1] + term[2] + term[3] + term[4];

		if (frame_ok && (&grp_ok)) begin
			res.zip   = value;
			res.error = 1'b0;
		end else begin
			res.zip   = '0;
			res.error = 1'b1;
		end
		res.bars = '0;
	end

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for postnet_zip_barcode_codec_unit.
// Holds the POSTNET codec predictor, a request driver with burst traffic and a
// result checker; depends only on pzbc_pkg and the codec top level.

module tb_top;

	// Stimulus sizes: directed rows first, then this many random requests.
	localparam int RANDOM_REQUESTS = 1050;
	localparam int DRAIN_CYCLES    = 12;
	localparam int REPORT_LIMIT    = 10;

	// Bar weights by bit position inside a group: bit 4 is the first bar.
	localparam logic [4:0][3:0] BAR_WEIGHT = {4'd7, 4'd4, 4'd2, 4'd1, 4'd0};

	// One directed stimulus row: payload plus an optional typed-in result.
	typedef struct {
		logic                        func;
		logic [pzbc_pkg::ZIP_W-1:0]  zip;
		logic [pzbc_pkg::BARS_W-1:0] bars;
		bit                          typed;
		pzbc_pkg::res_t              want;
	} stim_row_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic                        func      = pzbc_pkg::FUNC_ENCODE;
	logic [pzbc_pkg::ZIP_W-1:0]  zip_in    = '0;
	logic [pzbc_pkg::BARS_W-1:0] bars_in   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [pzbc_pkg::ZIP_W-1:0]  zip_out;
	logic [pzbc_pkg::BARS_W-1:0] bars_out;
	logic                        error;

	pzbc_pkg::res_t owed_codes_q[$];
	stim_row_t      directed_rows[$];
	int             mismatch_count = 0;
	int             burst_left     = 0;

	postnet_zip_barcode_codec_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.zip_in    (zip_in),
		.bars_in   (bars_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.zip_out   (zip_out),
		.bars_out  (bars_out),
		.error     (error)
	);

	always #1 clk = ~clk;

	// Two-of-five bar group for one decimal digit; digits above nine get no bars.
	function automatic logic [pzbc_pkg::GRP_W-1:0] bars_for_digit(input int unsigned d);
		logic [pzbc_pkg::GRP_W-1:0] g;
		unique case (d)
			0: g = 5'b11000;
			1: g = 5'b00011;
			2: g = 5'b00101;
			3: g = 5'b00110;
			4: g = 5'b01001;
			5: g = 5'b01010;
			6: g = 5'b01100;
			7: g = 5'b10001;
			8: g = 5'b10010;
			9: g = 5'b10100;
			default: g = '0;
		endcase
		return g;
	endfunction

	// Predict the result of one request: encode ZIP to bars or decode bars to ZIP.
	function automatic pzbc_pkg::res_t postnet_convert(input logic f,
			input logic [pzbc_pkg::ZIP_W-1:0] z, input logic [pzbc_pkg::BARS_W-1:0] b);
		pzbc_pkg::res_t             r;
		int unsigned                digit [pzbc_pkg::DIGITS];
		int unsigned                rest;
		int unsigned                ones;
		int unsigned                total;
		logic [pzbc_pkg::GRP_W-1:0] g;
		r = '0;
		if (f == pzbc_pkg::FUNC_ENCODE) begin
			// The leading digit may reach 13; the other four come from the remainder.
			digit[0] = z / 10000;
			rest     = z % 10000;
			digit[1] = rest / 1000;
			digit[2] = (rest / 100) % 10;
			digit[3] = (rest / 10) % 10;
			digit[4] = rest % 10;
			r.bars[pzbc_pkg::BARS_W-1] = 1'b1;
			r.bars[0]                  = 1'b1;
			for (int i = 0; i < pzbc_pkg::DIGITS; i++) begin
				r.bars[25-5*i -: 5] = bars_for_digit(digit[i]);
				if (digit[i] > 9)
					r.error = 1'b1;
			end
		end else begin
			// Any missing frame bar or malformed group leaves ZIP at 0 with error set.
			if (!b[pzbc_pkg::BARS_W-1] || !b[0]) begin
				r.error = 1'b1;
				return r;
			end
			for (int i = 0; i < pzbc_pkg::DIGITS; i++) begin
				g     = b[25-5*i -: 5];
				ones  = 0;
				total = 0;
				for (int p = 0; p < pzbc_pkg::GRP_W; p++) begin
					if (g[p]) begin
						ones++;
						total += BAR_WEIGHT[p];
					end
				end
				if (ones != 2) begin
					r.zip   = '0;
					r.error = 1'b1;
					return r;
				end
				// Bars 7 and 4 together stand for zero.
				if (total == 11)
					total = 0;
				r.zip = pzbc_pkg::ZIP_W'(r.zip * 10 + total);
			end
		end
		return r;
	endfunction

	task automatic add_row(input logic f, input logic [pzbc_pkg::ZIP_W-1:0] z,
			input logic [pzbc_pkg::BARS_W-1:0] b, input bit typed,
			input logic [pzbc_pkg::ZIP_W-1:0] wz, input logic [pzbc_pkg::BARS_W-1:0] wb,
			input logic we);
		stim_row_t row;
		row.func  = f;
		row.zip   = z;
		row.bars  = b;
		row.typed = typed;
		row.want  = '{zip: wz, bars: wb, error: we};
		directed_rows = {directed_rows, row};
	endtask

	// Present one request, hold it until the codec takes it, and record its result.
	// Called and returning just after a rising edge.
	task automatic drive_request(input logic f, input logic [pzbc_pkg::ZIP_W-1:0] z,
			input logic [pzbc_pkg::BARS_W-1:0] b, input pzbc_pkg::res_t want);
		int gap;
		// Pick a new burst when the current one runs out; some bursts start back to back.
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func     <= f;
		zip_in   <= z;
		bars_in  <= b;
		// Inputs settle between edges, so the negedge view decides the next edge.
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		owed_codes_q = {owed_codes_q, want};
		@(posedge clk);
	endtask

	// Receiver: stall in one of four random modes, picked anew when the current one runs out.
	int          ready_mode  = 0;
	int          ready_left  = 0;
	logic [7:0]  ready_mask  = 8'hFF;
	int unsigned ready_phase = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (ready_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				ready_left = $urandom_range(32, 200);
				ready_mask = 8'($urandom_range(1, 255));
			end
			ready_left--;
			ready_phase++;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ready_mask[ready_phase % 8];
			endcase
		end
	end

	// Checker: a result taken at the next edge is compared with the oldest owed code.
	pzbc_pkg::res_t owed;

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (owed_codes_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: zip=%0d bars=%h error=%b",
						zip_out, bars_out, error);
			end else begin
				owed = owed_codes_q.pop_front();
				if (zip_out !== owed.zip || bars_out !== owed.bars
						|| error !== owed.error) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: want zip=%0d bars=%h err=%b, got %0d %h %b",
							owed.zip, owed.bars, owed.error, zip_out, bars_out, error);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random traffic, drain.
	initial begin
		logic                        f;
		logic [pzbc_pkg::ZIP_W-1:0]  z;
		logic [pzbc_pkg::BARS_W-1:0] b;
		int                          kind;
		pzbc_pkg::res_t              want;

		// Encode rows: range ends, leading digit past nine, ignored bar input.
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd0, '0, 1, '0, {1'b1, {5{5'b11000}}, 1'b1}, 1'b0);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd99999, '0, 1, '0,
			{1'b1, {5{5'b10100}}, 1'b1}, 1'b0);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd100000, '0, 1, '0,
			{1'b1, 5'b00000, {4{5'b11000}}, 1'b1}, 1'b1);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd131071, '1, 1, '0,
			{1'b1, 5'b00000, 5'b00011, 5'b11000, 5'b10001, 5'b00011, 1'b1}, 1'b1);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd12345, '0, 0, '0, '0, 1'b0);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd67890, '0, 0, '0, '0, 1'b0);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd10000, '0, 0, '0, '0, 1'b0);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd54321, '1, 0, '0, '0, 1'b0);
		add_row(pzbc_pkg::FUNC_ENCODE, 17'd9, '0, 0, '0, '0, 1'b0);
		// Decode rows: frame faults, group faults, extremes, every digit pattern.
		add_row(pzbc_pkg::FUNC_DECODE, '0, '0, 1, '0, '0, 1'b1);
		add_row(pzbc_pkg::FUNC_DECODE, '0, '1, 1, '0, '0, 1'b1);
		add_row(pzbc_pkg::FUNC_DECODE, '0, {1'b0, {5{5'b10100}}, 1'b1}, 1, '0, '0, 1'b1);
		add_row(pzbc_pkg::FUNC_DECODE, '0, {1'b1, {5{5'b10100}}, 1'b0}, 1, '0, '0, 1'b1);
		add_row(pzbc_pkg::FUNC_DECODE, '0, {1'b1, {5{5'b11000}}, 1'b1}, 1, 17'd0, '0, 1'b0);
		add_row(pzbc_pkg::FUNC_DECODE, '0, {1'b1, {5{5'b10100}}, 1'b1}, 1, 17'd99999, '0,
			1'b0);
		add_row(pzbc_pkg::FUNC_DECODE, '0, {1'b1, 5'b00001, {4{5'b11000}}, 1'b1}, 1, '0, '0,
			1'b1);
		add_row(pzbc_pkg::FUNC_DECODE, '0, {1'b1, {4{5'b11000}}, 5'b11100, 1'b1}, 1, '0, '0,
			1'b1);
		add_row(pzbc_pkg::FUNC_DECODE, '0,
			{1'b1, {2{5'b11000}}, 5'b00000, {2{5'b11000}}, 1'b1}, 1, '0, '0, 1'b1);
		add_row(pzbc_pkg::FUNC_DECODE, '0,
			{1'b1, 5'b00011, 5'b00101, 5'b00110, 5'b01001, 5'b01010, 1'b1}, 0, '0, '0, 1'b0);
		add_row(pzbc_pkg::FUNC_DECODE, '1,
			{1'b1, 5'b01100, 5'b10001, 5'b10010, 5'b10100, 5'b11000, 1'b1}, 0, '0, '0, 1'b0);

		// Hold reset, then release it on a rising edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			want = directed_rows[k].typed ? directed_rows[k].want :
				postnet_convert(directed_rows[k].func, directed_rows[k].zip,
					directed_rows[k].bars);
			drive_request(directed_rows[k].func, directed_rows[k].zip,
				directed_rows[k].bars, want);
		end

		// Random traffic: mostly encodes and well-formed codes, some damaged codes and noise.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			kind = $urandom_range(0, 99);
			z    = pzbc_pkg::ZIP_W'($urandom_range(0, 131071));
			b    = pzbc_pkg::BARS_W'($urandom);
			if (kind < 40) begin
				f = pzbc_pkg::FUNC_ENCODE;
				z = ($urandom_range(0, 9) == 0) ?
					pzbc_pkg::ZIP_W'($urandom_range(100000, 131071)) :
					pzbc_pkg::ZIP_W'($urandom_range(0, 99999));
			end else begin
				f = pzbc_pkg::FUNC_DECODE;
				if (kind < 90) begin
					want = postnet_convert(pzbc_pkg::FUNC_ENCODE,
						pzbc_pkg::ZIP_W'($urandom_range(0, 99999)), '0);
					b    = want.bars;
					// Damage one bar: a frame bar or a group count goes wrong.
					if (kind >= 80)
						b[$urandom_range(0, pzbc_pkg::BARS_W-1)] ^= 1'b1;
				end
			end
			drive_request(f, z, b, postnet_convert(f, z, b));
		end
		in_valid <= 1'b0;

		// Drain: wait for every owed result, then keep waiting for strays.
		while (owed_codes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
